[rtl/abct_pkg.sv]
`timescale 1ns / 1ps
package abct_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int OFFSET_BITS_DEF = 32;
  localparam int CFG_W = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AGED_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_PERSIST = 2'd2;

  localparam logic [31:0] AGE_GUARD = 32'd3;
  localparam logic [31:0] RESIDENT_MIN = 32'd5;
  localparam logic [15:0] REFS_MAX = 16'hFFFF;
  localparam logic [31:0] AGE_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    MODE_PEEK = 2'd0,
    MODE_LOAD = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_SWEEP = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_PEEK_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [31:0] offset;
    logic [31:0] keep_count;
  } req_t;

  typedef struct packed {
    logic hit;
    logic created;
    logic [5:0] slot;
    logic [31:0] block_base;
    logic [6:0] freed;
    logic [1:0] status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_DECIDE,
    S_SHIFT,
    S_RELEASE,
    S_AUTO,
    S_SW_START,
    S_SWEEP,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch_req;
    logic find_init;
    logic find_step;
    logic take;
    logic shift_init;
    logic shift_step;
    logic insert;
    logic release_do;
    logic auto_calc;
    logic sweep_init;
    logic sweep_step;
    logic sweep_end;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] mode;
    logic find_done;
    logic found;
    logic full;
    logic shift_done;
    logic rel_ok;
    logic rel_zero;
    logic auto_need;
    logic sweep_skip;
    logic sweep_done;
  } sts_t;

endpackage

[rtl/aged_block_cache_table_unit.sv]
`timescale 1ns / 1ps
// Aged block cache table. One transaction at a time: pulse start with a
// request while busy is low; the result appears for one cycle with done high,
// in the cycle in which busy falls, and must be captured then since the
// receiver cannot stall. Busy time is set by the entry memory, whose one read
// port is synchronous, so each entry visited is first read and then compared.
// A lookup walks the sorted entries until one is not below the block base or
// the end is reached, then passes DECIDE and DONE; an insert first moves each
// larger entry up one slot; a release adds its update and, when the count
// drops to zero, an automatic sweep check; a sweep adds a start step and a
// walk over all entries. An explicit sweep skips the walk when nothing is old
// enough. The longest transaction is a release at the last slot of a full
// table that triggers an automatic sweep. Configuration writes
// (cfg_we/cfg_index/cfg_data) take effect at once.
module aged_block_cache_table_unit #(
  parameter int OFFSET_BITS = abct_pkg::OFFSET_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  abct_pkg::req_t req,
  output logic done,
  output abct_pkg::rsp_t rsp,
  input  logic cfg_we,
  input  logic [abct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [abct_pkg::CFG_W-1:0] cfg_data
);
  import abct_pkg::*;

  logic [4:0] block_size_log2;
  logic [6:0] aged_limit_blocks;
  logic keep_most;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size_log2 <= 5'd10;
      aged_limit_blocks <= 7'd32;
      keep_most <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_SIZE_LOG2: block_size_log2 <= cfg_data[4:0];
        REG_AGED_LIMIT: aged_limit_blocks <= cfg_data;
        REG_HIGH_PERSIST: keep_most <= cfg_data[0];
        default: ;
      endcase
    end
  end

  abct_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  abct_dp #(.OFFSET_BITS(OFFSET_BITS)) u_dp (
    .clk(clk), .rst(rst), .req(req), .block_size_log2(block_size_log2),
    .aged_limit_blocks(aged_limit_blocks), .keep_most(keep_most),
    .cmd(cmd), .sts(sts), .done(done), .rsp(rsp)
  );

  // a result always closes a transaction that was accepted
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without transaction");
  // an accepted request raises busy
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised");
endmodule

[rtl/abct_ctrl.sv]
`timescale 1ns / 1ps
module abct_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  abct_pkg::sts_t sts,
  output abct_pkg::cmd_t cmd
);
  import abct_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_FIND;
      end
      S_FIND: begin
        if (sts.mode == MODE_SWEEP) state_next = S_SW_START;
        else if (sts.find_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.mode == MODE_RELEASE) state_next = S_RELEASE;
        else if (!sts.found && sts.mode == MODE_LOAD && !sts.full) state_next = S_SHIFT;
        else state_next = S_DONE;
      end
      S_SHIFT: begin
        if (sts.shift_done) state_next = S_DONE;
      end
      S_RELEASE: begin
        if (sts.rel_ok && sts.rel_zero) state_next = S_AUTO;
        else state_next = S_DONE;
      end
      S_AUTO: begin
        if (sts.auto_need) state_next = S_SW_START;
        else state_next = S_DONE;
      end
      S_SW_START: begin
        if (sts.sweep_skip) state_next = S_DONE;
        else state_next = S_SWEEP;
      end
      S_SWEEP: begin
        if (sts.sweep_done) state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        cmd.latch_req = start;
        cmd.find_init = start;
      end
      S_FIND: cmd.find_step = (sts.mode != MODE_SWEEP) && !sts.find_done;
      S_DECIDE: begin
        cmd.take = (sts.mode == MODE_PEEK || sts.mode == MODE_LOAD) && sts.found;
        cmd.shift_init = !sts.found && sts.mode == MODE_LOAD && !sts.full;
      end
      S_SHIFT: begin
        cmd.shift_step = !sts.shift_done;
        cmd.insert = sts.shift_done;
      end
      S_RELEASE: cmd.release_do = 1'b1;
      S_AUTO: cmd.auto_calc = 1'b1;
      S_SW_START: cmd.sweep_init = 1'b1;
      S_SWEEP: begin
        cmd.sweep_step = !sts.sweep_done;
        cmd.sweep_end = sts.sweep_done;
      end
      S_DONE: cmd.emit = 1'b1;
      default: cmd = '0;
    endcase
  end
endmodule

[rtl/abct_dp.sv]
`timescale 1ns / 1ps
module abct_dp #(
  parameter int OFFSET_BITS = abct_pkg::OFFSET_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  abct_pkg::req_t req,
  input  logic [4:0] block_size_log2,
  input  logic [6:0] aged_limit_blocks,
  input  logic keep_most,
  input  abct_pkg::cmd_t cmd,
  output abct_pkg::sts_t sts,
  output logic done,
  output abct_pkg::rsp_t rsp
);
  import abct_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int DW = OFFSET_BITS + 16 + 32;

  // one entry = {base, refs, age}; single memory, sync read
  logic [DW-1:0] mem [MAX_ENTRIES];
  logic [DW-1:0] rd_data;
  logic [IW-1:0] rd_addr;
  logic we;
  logic [IW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  wire [OFFSET_BITS-1:0] rd_base = rd_data[DW-1 -: OFFSET_BITS];
  wire [15:0] rd_refs = rd_data[47:32];
  wire [31:0] rd_age = rd_data[31:0];

  logic [1:0] mode;
  logic [OFFSET_BITS-1:0] base;
  logic [CW-1:0] entry_count;
  logic [31:0] top_age;
  logic [6:0] idle_count;

  logic [CW-1:0] pos;       // scan index
  logic rd_pend;            // read of entry pos issued, compare next cycle
  logic found;
  logic find_done;
  logic [15:0] cur_refs;
  logic [31:0] cur_age;
  logic [CW-1:0] j;         // shift index
  logic sh_ph;
  logic [CW-1:0] rd_i, wr_i;
  logic [31:0] rej;
  logic [31:0] keep_k;
  logic [6:0] nfreed;
  logic sw_ph;
  logic [6:0] freed_r;
  logic [1:0] status_r;
  logic created_r;
  logic [15:0] refs_dec;
  logic stamp;
  logic [31:0] top_inc;
  logic [6:0] idle_inc;
  logic [7:0] ov_raw;
  logic [CW-1:0] ov, n_half, k_hp, k_sel;
  logic [31:0] keep_eff;

  wire [OFFSET_BITS-1:0] off_w = OFFSET_BITS'(req.offset);
  wire [OFFSET_BITS-1:0] bmask = ~((OFFSET_BITS'(1) << block_size_log2) - OFFSET_BITS'(1));

  // Find: read entry pos, compare in the next cycle.
  // find_done when pos reached count or rd entry >= base.
  always_comb begin
    rd_addr = pos[IW-1:0];
    if (cmd.shift_step && !sh_ph) rd_addr = IW'(j - CW'(1));
    if (cmd.sweep_step || cmd.sweep_init) rd_addr = rd_i[IW-1:0];
    if (cmd.take || cmd.release_do) rd_addr = pos[IW-1:0];
  end

  assign refs_dec = cur_refs - 16'd1;
  assign stamp = (({1'b0, cur_age} + 33'd3) <= {1'b0, top_age}) || (top_age < AGE_GUARD);
  assign top_inc = (top_age < AGE_MAX) ? top_age + 32'd1 : top_age;
  assign idle_inc = idle_count + 7'd1;

  always_comb begin
    ov_raw = {1'b0, idle_count} - {1'b0, aged_limit_blocks} + 8'(aged_limit_blocks >> 4);
    ov = (CW'(ov_raw) > entry_count || 32'(ov_raw) > 32'(entry_count)) ? entry_count
         : CW'(ov_raw);
    n_half = entry_count >> 1;
    k_hp = n_half + (n_half >> 1);
    if (entry_count - ov > k_hp) k_hp = entry_count - ov;
    k_sel = keep_most ? k_hp : (entry_count >> 2);
  end

  assign keep_eff = (keep_k < AGE_GUARD) ? AGE_GUARD : keep_k;

  always_comb begin
    we = 1'b0;
    wr_addr = pos[IW-1:0];
    wr_data = rd_data;
    if (cmd.take && cur_refs != REFS_MAX) begin
      we = 1'b1;
      wr_data = {base, cur_refs + 16'd1, cur_age};
    end
    if (cmd.shift_step && sh_ph) begin
      we = 1'b1;
      wr_addr = j[IW-1:0];
    end
    if (cmd.insert) begin
      we = 1'b1;
      wr_data = {base, 16'd1, 32'd0};
    end
    if (cmd.release_do && found && cur_refs != 16'd0) begin
      we = 1'b1;
      wr_data = {base, refs_dec, (refs_dec == 16'd0 && stamp) ? top_inc : cur_age};
    end
    if (cmd.sweep_step && sw_ph && rd_i != CW'(0) && !(rd_refs == 16'd0 && rd_age <= rej)) begin
      we = 1'b1;
      wr_addr = wr_i[IW-1:0];
      wr_data = {rd_base, rd_refs, rd_age - ((rej < rd_age) ? rej : rd_age)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      top_age <= '0;
      idle_count <= '0;
      pos <= '0;
      rd_pend <= 1'b0;
      found <= 1'b0;
      find_done <= 1'b0;
      sh_ph <= 1'b0;
      sw_ph <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.latch_req) begin
        mode <= req.mode;
        keep_k <= req.keep_count;
        base <= off_w & bmask;
        status_r <= ST_OK;
        created_r <= 1'b0;
        freed_r <= '0;
      end
      if (cmd.find_init) begin
        pos <= '0;
        rd_pend <= 1'b0;
        found <= 1'b0;
        find_done <= (entry_count == '0);
      end
      if (cmd.find_step) begin
        if (!rd_pend) begin
          rd_pend <= 1'b1;
        end else begin
          rd_pend <= 1'b0;
          if (rd_base >= base) begin
            find_done <= 1'b1;
            found <= (rd_base == base);
            cur_refs <= rd_refs;
            cur_age <= rd_age;
          end else if (pos + CW'(1) >= entry_count) begin
            pos <= pos + CW'(1);
            find_done <= 1'b1;
          end else begin
            pos <= pos + CW'(1);
          end
        end
      end
      if (cmd.take) begin
        if (cur_refs != REFS_MAX) begin
          if (cur_refs == 16'd0 && idle_count != 7'd0) idle_count <= idle_count - 7'd1;
        end
      end
      if (mode != MODE_SWEEP && find_done && !cmd.find_step && cmd.take == 1'b0 &&
          cmd.shift_init) begin
        j <= entry_count;
        sh_ph <= 1'b0;
      end
      if (cmd.shift_step) sh_ph <= ~sh_ph;
      if (cmd.shift_step && sh_ph) j <= j - CW'(1);
      if (cmd.insert) begin
        entry_count <= entry_count + CW'(1);
        created_r <= 1'b1;
      end
      if (cmd.emit) begin
        if (mode == MODE_PEEK && !found) status_r <= ST_PEEK_MISS;
      end
      if (cmd.release_do) begin
        if (!found || cur_refs == 16'd0) begin
          status_r <= ST_ABSENT;
        end else if (refs_dec == 16'd0) begin
          if (stamp) top_age <= top_inc;
          idle_count <= idle_inc;
        end
      end
      if (cmd.auto_calc) begin
        keep_k <= (32'(k_sel) < RESIDENT_MIN) ? RESIDENT_MIN : 32'(k_sel);
      end
      if (cmd.sweep_init) begin
        rej <= top_age - keep_eff;
        keep_k <= keep_eff;
        rd_i <= '0;
        wr_i <= '0;
        nfreed <= '0;
        sw_ph <= 1'b0;
      end
      if (cmd.sweep_step) begin
        // sw_ph=0: issue read of rd_i; sw_ph=1: rd_data valid for rd_i-1
        if (!sw_ph) begin
          sw_ph <= 1'b1;
          rd_i <= rd_i + CW'(1);
        end else begin
          if (rd_refs == 16'd0 && rd_age <= rej) nfreed <= nfreed + 7'd1;
          else wr_i <= wr_i + CW'(1);
          sw_ph <= 1'b0;
        end
      end
      if (cmd.sweep_end) begin
        entry_count <= wr_i;
        top_age <= keep_k;
        idle_count <= (idle_count >= nfreed) ? idle_count - nfreed : 7'd0;
        freed_r <= nfreed;
      end
    end
  end

  wire full_w = (entry_count >= CW'(MAX_ENTRIES));

  always_comb begin
    sts = '0;
    sts.mode = mode;
    sts.find_done = find_done;
    sts.found = found;
    sts.full = full_w;
    sts.shift_done = (j <= pos) && !sh_ph;
    sts.rel_ok = found && cur_refs != 16'd0;
    sts.rel_zero = (refs_dec == 16'd0);
    sts.auto_need = (idle_count > aged_limit_blocks);
    sts.sweep_skip = (keep_eff >= top_age);
    sts.sweep_done = (rd_i >= entry_count) && !sw_ph;
  end

  always_comb begin
    rsp = '0;
    rsp.hit = (mode != MODE_SWEEP) && found;
    rsp.created = created_r;
    rsp.slot = (mode != MODE_SWEEP) ? 6'(pos) : 6'd0;
    rsp.block_base = (mode != MODE_SWEEP) ? 32'(base) : 32'd0;
    rsp.freed = freed_r;
    rsp.status = (mode == MODE_LOAD && !found && !created_r) ? ST_FULL : status_r;
  end
endmodule

[sim/tb_aged_block_cache_table_unit.sv]
`timescale 1ns / 1ps
// Testbench for the aged block cache table.
// Requests (peek, load, release, sweep) are queued by the stimulus process,
// issued by a clocked driver with random start gaps, and checked one by one
// against an in-bench model of the sorted table as each done strobe arrives.
module tb_aged_block_cache_table_unit;
  import abct_pkg::*;

  localparam int TBL_DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int END_DRAIN = 600;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  rsp_t rsp;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  aged_block_cache_table_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Table model: configuration plus a sorted copy of the entries
  // ---------------------------------------------------------------------------
  logic [4:0] m_blk_log2;
  logic [6:0] m_aged_limit;
  logic m_high_persist;
  logic [31:0] m_base[TBL_DEPTH];
  logic [15:0] m_refs[TBL_DEPTH];
  logic [31:0] m_age[TBL_DEPTH];
  int unsigned m_count;
  logic [31:0] m_top_age;
  int unsigned m_idle;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];

  int unsigned n_mismatch;
  int unsigned n_issued;
  int unsigned quiet_cycles;
  logic no_gaps;
  int unsigned gap_left;

  // sweep unreferenced entries whose age is at most top_age - keep; returns count freed
  function automatic int unsigned table_sweep(logic [31:0] keep);
    logic [31:0] cut;
    logic [31:0] a;
    int unsigned wr;
    int unsigned nfree;
    wr = 0;
    nfree = 0;
    if (keep < AGE_GUARD) keep = AGE_GUARD;
    if (keep >= m_top_age) return 0;
    cut = m_top_age - keep;
    for (int rd = 0; rd < m_count; rd++) begin
      if (m_refs[rd] == 0 && m_age[rd] <= cut) begin
        nfree++;
      end else begin
        a = m_age[rd];
        m_age[wr] = a - ((cut < a) ? cut : a);
        m_base[wr] = m_base[rd];
        m_refs[wr] = m_refs[rd];
        wr++;
      end
    end
    m_count = wr;
    m_top_age = keep;
    m_idle = (m_idle >= nfree) ? m_idle - nfree : 0;
    return nfree;
  endfunction

  function automatic rsp_t table_apply(req_t r);
    rsp_t o;
    logic [31:0] base;
    int unsigned pos;
    logic found;
    int unsigned n, ov, k;
    o = '0;
    base = r.offset & ~((32'd1 << m_blk_log2) - 32'd1);
    if (mode_t'(r.mode) == MODE_SWEEP) begin
      o.freed = 7'(table_sweep(r.keep_count));
      return o;
    end
    pos = 0;
    while (pos < m_count && m_base[pos] < base) pos++;
    found = (pos < m_count) && (m_base[pos] == base);
    o.slot = 6'(pos);
    o.block_base = base;
    o.hit = found;
    o.status = ST_OK;
    if (mode_t'(r.mode) == MODE_PEEK || mode_t'(r.mode) == MODE_LOAD) begin
      if (found) begin
        if (m_refs[pos] != REFS_MAX) begin
          if (m_refs[pos] == 0 && m_idle > 0) m_idle--;
          m_refs[pos]++;
        end
      end else if (mode_t'(r.mode) == MODE_PEEK) begin
        o.status = ST_PEEK_MISS;
      end else if (m_count >= TBL_DEPTH) begin
        o.status = ST_FULL;
      end else begin
        for (int j = m_count; j > pos; j--) begin
          m_base[j] = m_base[j-1];
          m_refs[j] = m_refs[j-1];
          m_age[j] = m_age[j-1];
        end
        m_base[pos] = base;
        m_refs[pos] = 1;
        m_age[pos] = 0;
        m_count++;
        o.created = 1'b1;
      end
    end else if (!found || m_refs[pos] == 0) begin
      o.status = ST_ABSENT;
    end else begin
      m_refs[pos]--;
      if (m_refs[pos] == 0) begin
        if ({1'b0, m_age[pos]} + 33'(AGE_GUARD) <= {1'b0, m_top_age}
            || m_top_age < AGE_GUARD) begin
          if (m_top_age != AGE_MAX) m_top_age++;
          m_age[pos] = m_top_age;
        end
        m_idle++;
        // automatic sweep once too many blocks sit unreferenced
        if (m_idle > m_aged_limit) begin
          n = m_count;
          if (m_high_persist) begin
            ov = m_idle - m_aged_limit + (m_aged_limit >> 4);
            if (ov > n) ov = n;
            k = n >> 1;
            k += k >> 1;
            if (n - ov > k) k = n - ov;
          end else begin
            k = n >> 2;
          end
          if (k < RESIDENT_MIN) k = RESIDENT_MIN;
          o.freed = 7'(table_sweep(32'(k)));
        end
      end
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: start is held high until accepted, with random bursts of gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        expected_rsps.push_back(table_apply(req));
        n_issued <= n_issued + 1;
      end
      if (start && busy) begin
        // hold request until accepted
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
        start <= 1'b0;
        gap_left <= $urandom_range(0, 7);
      end else if (pending_reqs.size() > 0) begin
        start <= 1'b1;
        req <= pending_reqs.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every done strobe is compared with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        n_mismatch <= n_mismatch + 1;
        if (n_mismatch < 10) $display("unexpected result %h", rsp);
      end else begin
        exp_r = expected_rsps.pop_front();
        if (rsp.hit !== exp_r.hit || rsp.created !== exp_r.created
            || rsp.slot !== exp_r.slot || rsp.block_base !== exp_r.block_base
            || rsp.freed !== exp_r.freed || rsp.status !== exp_r.status) begin
          n_mismatch <= n_mismatch + 1;
          if (n_mismatch < 10) begin
            $display("mismatch: exp hit=%b cr=%b slot=%0d base=%h freed=%0d st=%0d",
                     exp_r.hit, exp_r.created, exp_r.slot, exp_r.block_base,
                     exp_r.freed, exp_r.status);
            $display("          got hit=%b cr=%b slot=%0d base=%h freed=%0d st=%0d",
                     rsp.hit, rsp.created, rsp.slot, rsp.block_base, rsp.freed,
                     rsp.status);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic req_t make_req(mode_t m, logic [31:0] off, logic [31:0] kc);
    req_t r;
    r.mode = m;
    r.offset = off;
    r.keep_count = kc;
    return r;
  endfunction

  // offsets from a small pool of blocks so hits and releases are common
  function automatic logic [31:0] pick_offset();
    logic [31:0] blk;
    if ($urandom_range(0, 15) == 0) return $urandom;
    blk = $urandom_range(0, 47);
    if ($urandom_range(0, 7) == 0) blk = blk | 32'hFFFF_FFC0;
    return (blk << m_blk_log2) | ($urandom & ((32'd1 << m_blk_log2) - 1));
  endfunction

  function automatic logic [31:0] pick_keep();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 3);
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BLOCK_SIZE_LOG2: m_blk_log2 = val[4:0];
      REG_AGED_LIMIT: m_aged_limit = val;
      default: m_high_persist = val[0];
    endcase
  endtask

  // wait until all queued requests are issued and answered; sampled on the
  // falling edge so the driver's updates at the rising edge have settled
  task automatic drain();
    @(negedge clk);
    while (pending_reqs.size() > 0 || start || busy || expected_rsps.size() > 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(int unsigned nreq);
    int unsigned sel;
    for (int i = 0; i < nreq; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) pending_reqs.push_back(make_req(MODE_LOAD, pick_offset(), 0));
      else if (sel < 80) pending_reqs.push_back(make_req(MODE_RELEASE, pick_offset(), 0));
      else if (sel < 93) pending_reqs.push_back(make_req(MODE_PEEK, pick_offset(), $urandom));
      else pending_reqs.push_back(make_req(MODE_SWEEP, $urandom, pick_keep()));
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    n_mismatch = 0;
    n_issued = 0;
    quiet_cycles = 0;
    no_gaps = 1'b0;
    gap_left = 0;
    m_blk_log2 = 5'd10;
    m_aged_limit = 7'd32;
    m_high_persist = 1'b0;
    m_count = 0;
    m_top_age = '0;
    m_idle = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: misses, inserts, hits, release edge cases, sweeps
    cfg_write(REG_BLOCK_SIZE_LOG2, 7'd4);
    pending_reqs.push_back(make_req(MODE_PEEK, 32'h0, 32'h0));
    pending_reqs.push_back(make_req(MODE_RELEASE, 32'h10, 0));
    pending_reqs.push_back(make_req(MODE_SWEEP, 0, 0));
    pending_reqs.push_back(make_req(MODE_LOAD, 32'hFFFF_FFFF, 0));
    pending_reqs.push_back(make_req(MODE_LOAD, 32'h0000_0000, 0));
    pending_reqs.push_back(make_req(MODE_LOAD, 32'h0000_0025, 0));
    pending_reqs.push_back(make_req(MODE_LOAD, 32'h0000_0021, 0));
    pending_reqs.push_back(make_req(MODE_PEEK, 32'h0000_002F, 0));
    pending_reqs.push_back(make_req(MODE_RELEASE, 32'h0000_0020, 0));
    pending_reqs.push_back(make_req(MODE_RELEASE, 32'h0000_0020, 0));
    pending_reqs.push_back(make_req(MODE_RELEASE, 32'h0000_0020, 0));
    pending_reqs.push_back(make_req(MODE_RELEASE, 32'h0000_0020, 0));
    pending_reqs.push_back(make_req(MODE_RELEASE, 32'h0000_0000, 0));
    pending_reqs.push_back(make_req(MODE_RELEASE, 32'hFFFF_FFF0, 0));
    pending_reqs.push_back(make_req(MODE_SWEEP, 0, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(MODE_SWEEP, 0, 32'd1));
    pending_reqs.push_back(make_req(MODE_PEEK, 32'h0000_0000, 0));
    drain();

    // fill the table to full: 70 distinct loads
    cfg_write(REG_BLOCK_SIZE_LOG2, 7'd16);
    for (int i = 0; i < 70; i++)
      pending_reqs.push_back(make_req(MODE_LOAD, (32'(69 - i)) << 16, 0));
    drain();
    // release everything with a small limit, high persistency
    cfg_write(REG_AGED_LIMIT, 7'd0);
    cfg_write(REG_HIGH_PERSIST, 7'd1);
    for (int i = 0; i < 70; i++)
      pending_reqs.push_back(make_req(MODE_RELEASE, 32'(i) << 16, 0));
    drain();
    cfg_write(REG_BLOCK_SIZE_LOG2, 7'd31);
    pending_reqs.push_back(make_req(MODE_LOAD, 32'h8000_1234, 0));
    pending_reqs.push_back(make_req(MODE_PEEK, 32'h7FFF_FFFF, 0));
    drain();

    // random phases across several settings
    cfg_write(REG_BLOCK_SIZE_LOG2, 7'd4);
    cfg_write(REG_AGED_LIMIT, 7'd64);
    cfg_write(REG_HIGH_PERSIST, 7'd0);
    random_phase(200);
    drain();
    cfg_write(REG_BLOCK_SIZE_LOG2, 7'd10);
    cfg_write(REG_AGED_LIMIT, 7'd8);
    cfg_write(REG_HIGH_PERSIST, 7'd1);
    random_phase(200);
    drain();
    cfg_write(REG_BLOCK_SIZE_LOG2, 7'd0);
    cfg_write(REG_AGED_LIMIT, 7'd20);
    cfg_write(REG_HIGH_PERSIST, 7'd0);
    random_phase(150);
    drain();
    cfg_write(REG_BLOCK_SIZE_LOG2, 7'd7);
    cfg_write(REG_AGED_LIMIT, 7'd127);
    cfg_write(REG_HIGH_PERSIST, 7'd1);
    // last stretch runs back to back
    no_gaps = 1'b1;
    random_phase(150);
    drain();

    repeat (END_DRAIN) @(posedge clk);
    if (n_mismatch == 0 && expected_rsps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
